FILE: hdl/rdc_pkg.sv
// Shared types and constants for the radix digit converter.
// No dependencies; imported by rdc_ctrl, rdc_datapath and radix_digit_converter.
package rdc_pkg;

    // Field widths
    localparam int IN_W    = 31;            // digits_in / digits_out
    localparam int TDATA_W = 32;            // stream data, padded to whole bytes
    localparam int RADIX_W = 5;             // in_base / out_base registers
    localparam int REM_W   = RADIX_W - 1;   // remainder of a divide by a radix <= 16

    localparam logic [IN_W-1:0] VAL_MAX = 31'h7FFF_FFFF;

    // Decimal digit handling on the input side
    localparam int BCD_DIGITS    = 10;      // decimal digits in a 31-bit value
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int MAX_DIGITS    = 10;      // least significant digits that are read
    localparam int HORNER_DIGITS = (MAX_DIGITS < BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
    localparam int IDX_W         = $clog2(BCD_DIGITS);

    // Intermediate value: below 16^10
    localparam int VAL_W   = 40;
    localparam int DIV_BITS = 8;                    // long-division bits per cycle
    localparam int DIV_CYC  = VAL_W / DIV_BITS;

    // Output side: ten decimal places can carry weight, 10^9 fits in 30 bits
    localparam int OUT_DIGITS = 10;
    localparam int POS_W      = $clog2(OUT_DIGITS);
    localparam int PW_W       = 30;
    localparam int ACC_W      = 35;

    localparam int CNT_W = 5;               // covers IN_W-1 shift steps

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 2'd1;

    localparam logic [RADIX_W-1:0] IN_BASE_RST  = 5'd10;
    localparam logic [RADIX_W-1:0] OUT_BASE_RST = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MIN    = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;

    // Controller -> datapath commands
    typedef struct packed {
        logic             load;         // capture input, clear working registers
        logic             bcd_step;     // one double-dabble shift
        logic             horner_step;  // value = value * in_base + digit
        logic [IDX_W-1:0] digit_idx;    // decimal digit used by horner_step
        logic             div_step;     // DIV_BITS long-division steps by out_base
        logic             acc_step;     // fold remainder into the decimal result
        logic             ovf_chk;      // quotient left after the last place -> overflow
        logic             out_load;     // load the output register
    } rdc_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic value_zero;
    } rdc_status_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

endpackage

FILE: hdl/rdc_ctrl.sv
// Sequencing state machine for the radix digit converter.
// Depends on rdc_pkg (command/status types, step counts).
module rdc_ctrl
    import rdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  rdc_status_t status,
    output rdc_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_BCD    = 6'b000010,
        S_HORNER = 6'b000100,
        S_DIV    = 6'b001000,
        S_ACC    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.digit_idx  = cnt_reg[IDX_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_BCD;
                end
            end
            S_BCD:
            begin
                cmd.bcd_step = 1'b1;
                if (cnt_reg == CNT_W'(IN_W - 1))
                begin
                    cnt_next   = CNT_W'(HORNER_DIGITS - 1);
                    state_next = S_HORNER;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_HORNER:
            begin
                cmd.horner_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    pos_next   = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_CYC - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ACC;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_ACC:
            begin
                // value now holds the quotient; remainder is this place's digit
                cmd.acc_step = 1'b1;
                if (pos_reg == POS_W'(OUT_DIGITS - 1))
                begin
                    cmd.ovf_chk = 1'b1;
                    state_next  = S_DONE;
                end
                else if (status.value_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next   = pos_reg + POS_W'(1);
                    state_next = S_DIV;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hdl/rdc_datapath.sv
// Arithmetic for the radix digit converter: binary-to-BCD, Horner accumulate,
// long division by the output radix, decimal repacking. Depends on rdc_pkg.
module rdc_datapath
    import rdc_pkg::*;
(
    input  logic               clk,
    input  rdc_cmd_t           cmd,
    input  logic [IN_W-1:0]    digits_in,
    input  logic [RADIX_W-1:0] in_radix,
    input  logic [RADIX_W-1:0] out_radix,
    output rdc_status_t        status,
    output logic [IN_W-1:0]    digits_out,
    output logic               overflow
);

    logic [IN_W-1:0]    bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [PW_W-1:0]    pw_reg;
    logic               ovf_reg;
    logic [IN_W-1:0]    digits_out_reg;
    logic               overflow_reg;

    logic [BCD_W-1:0]           bcd_adj;
    logic [VAL_W+RADIX_W-1:0]   horner_prod;
    logic [VAL_W-1:0]           horner_next;
    logic [VAL_W-1:0]           div_val;
    logic [REM_W-1:0]           div_rem;
    logic [RADIX_W-1:0]         div_try;
    logic [REM_W+PW_W-1:0]      acc_prod;
    logic                       ovf_final;

    // double dabble: add 3 to every digit of five or more before the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    assign horner_prod = (VAL_W+RADIX_W)'(value_reg) * (VAL_W+RADIX_W)'(in_radix);
    assign horner_next = horner_prod[VAL_W-1:0]
                       + VAL_W'(bcd_reg[4*cmd.digit_idx +: 4]);

    // restoring division, DIV_BITS quotient bits per cycle, MSB first
    always_comb
    begin
        div_val = value_reg;
        div_rem = rem_reg;
        div_try = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            div_try = {div_rem, div_val[VAL_W-1]};
            div_val = {div_val[VAL_W-2:0], 1'b0};
            if (div_try >= out_radix)
            begin
                div_try    = div_try - out_radix;
                div_val[0] = 1'b1;
            end
            div_rem = div_try[REM_W-1:0];
        end
    end

    assign acc_prod  = (REM_W+PW_W)'(rem_reg) * (REM_W+PW_W)'(pw_reg);
    assign ovf_final = ovf_reg || (acc_reg > ACC_W'(VAL_MAX));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg   <= digits_in;
            bcd_reg   <= '0;
            value_reg <= '0;
            rem_reg   <= '0;
            acc_reg   <= '0;
            pw_reg    <= PW_W'(1);
            ovf_reg   <= 1'b0;
        end
        if (cmd.bcd_step)
        begin
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[IN_W-1]};
            bin_reg <= {bin_reg[IN_W-2:0], 1'b0};
        end
        if (cmd.horner_step)
        begin
            value_reg <= horner_next;
        end
        if (cmd.div_step)
        begin
            value_reg <= div_val;
            rem_reg   <= div_rem;
        end
        if (cmd.acc_step)
        begin
            acc_reg <= acc_reg + ACC_W'(acc_prod);
            pw_reg  <= PW_W'({pw_reg, 3'b000}) + PW_W'({pw_reg, 1'b0});
            rem_reg <= '0;
        end
        if (cmd.ovf_chk)
        begin
            // a nonzero digit beyond the tenth decimal place cannot be held
            ovf_reg <= (value_reg != '0);
        end
        if (cmd.out_load)
        begin
            digits_out_reg <= ovf_final ? VAL_MAX : acc_reg[IN_W-1:0];
            overflow_reg   <= ovf_final;
        end
    end

    assign status.value_zero = (value_reg == '0);
    assign digits_out        = digits_out_reg;
    assign overflow          = overflow_reg;

endmodule

FILE: hdl/radix_digit_converter.sv
// Radix digit converter: reads the decimal digits of a 31-bit input as digits of
// in_base, then writes the value's out_base digits as decimal places of the result.
// Depends on rdc_pkg, rdc_ctrl and rdc_datapath.
//
// One item is converted at a time. After an input transfer the block turns the
// input into decimal digits (double dabble, one bit a cycle), forms the value by
// Horner steps in in_base, then for each output place runs a 40-bit long
// division by out_base at 8 bits a cycle and a step that folds the digit into
// the decimal result. Conversion stops when the quotient reaches zero or after
// ten places. The result sits in an output register, so the next input is
// taken while it waits; a new result waits for that register to drain. Digits
// of the input at or above in_base are not rejected and just add their weight.
// Radix register values below 2 act as 2, above 16 as 16. A result above
// 2^31-1 gives 2^31-1 with tuser (overflow) set. Configuration writes are
// accepted every cycle (cfg_ready is tied high) and must only occur while the
// block is idle; an index past the register list is ignored.
module radix_digit_converter
    import rdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [TDATA_W-1:0]   s_axis_tdata,   // [30:0] digits_in, [31] unused

    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [30:0] digits_out, [31] zero
    output logic [0:0]           m_axis_tuser,   // [0] overflow

    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,      // 0: in_base, 1: out_base
    input  logic [RADIX_W-1:0]   cfg_data
);

    logic [RADIX_W-1:0] in_base_reg;
    logic [RADIX_W-1:0] out_base_reg;
    logic [RADIX_W-1:0] in_radix;
    logic [RADIX_W-1:0] out_radix;

    rdc_cmd_t           cmd;
    rdc_status_t        status;
    logic [IN_W-1:0]    digits_out;
    logic               overflow;

    // config registers; written only while idle by the user, not enforced here
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_base_reg  <= IN_BASE_RST;
            out_base_reg <= OUT_BASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IN_BASE:  in_base_reg  <= cfg_data;
                REG_OUT_BASE: out_base_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign in_radix  = clamp_radix(in_base_reg);
    assign out_radix = clamp_radix(out_base_reg);

    rdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    rdc_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .digits_in  (s_axis_tdata[IN_W-1:0]),
        .in_radix   (in_radix),
        .out_radix  (out_radix),
        .status     (status),
        .digits_out (digits_out),
        .overflow   (overflow)
    );

    assign m_axis_tdata    = {{(TDATA_W-IN_W){1'b0}}, digits_out};
    assign m_axis_tuser[0] = overflow;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // one item in flight: no second input transfer right after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a conversion is running");

    // saturation: an overflowed result reads as the maximum
    a_sat_on_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[IN_W-1:0] == VAL_MAX))
        else $error("overflow flagged without saturated result");

    // clamped radices always in 2..16
    a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_radix >= RADIX_MIN) && (in_radix <= RADIX_MAX)
        && (out_radix >= RADIX_MIN) && (out_radix <= RADIX_MAX))
        else $error("radix out of range after clamp");

endmodule
